FILE: src/owm_pkg.sv
// Package: shared types, timing constants and command codes for the bus master.
`timescale 1ns / 1ps
package owm_pkg;

  // Tick counter width and the width used to compare against phase lengths
  localparam int TIMER_BITS = 20;
  localparam int CFG_W      = 20;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef logic [TIMER_BITS-1:0] cnt_t;
  typedef logic [CMP_W-1:0]      len_t;

  localparam cnt_t TIMER_MAX = {TIMER_BITS{1'b1}};

  // Phase lengths in microseconds
  localparam len_t LEN_RST_LOW  = len_t'(480);
  localparam len_t LEN_RST_WAIT = len_t'(70);
  localparam len_t LEN_RST_REC  = len_t'(410);
  localparam len_t LEN_WR1_LOW  = len_t'(6);
  localparam len_t LEN_WR1_HIGH = len_t'(64);
  localparam len_t LEN_WR0_LOW  = len_t'(60);
  localparam len_t LEN_WR0_HIGH = len_t'(10);
  localparam len_t LEN_RD_LOW   = len_t'(6);
  localparam len_t LEN_RD_WAIT  = len_t'(9);
  localparam len_t LEN_RD_REC   = len_t'(55);

  localparam logic [CFG_W-1:0] CONV_WAIT_RESET = CFG_W'(750000);

  // Bus commands
  localparam logic [7:0] CMD_SKIP = 8'hCC;
  localparam logic [7:0] CMD_CONV = 8'h44;
  localparam logic [7:0] CMD_READ = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_CONV     = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_REC   = 4'd9
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic us_tick;
    logic line_level;
  } item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               status;
    logic signed [15:0] temperature_raw;
  } res_t;

endpackage

FILE: src/owm_if.sv
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
interface owm_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic us_tick;
  logic line_level;
  modport source (output valid, start_req, us_tick, line_level, input ready);
  modport sink   (input valid, start_req, us_tick, line_level, output ready);
endinterface

interface owm_out_if;
  logic               valid;
  logic               ready;
  logic               drive_low;
  logic               busy_res;
  logic               done_res;
  logic               status;
  logic signed [15:0] temperature_raw;
  modport source (output valid, drive_low, busy_res, done_res, status, temperature_raw,
                  input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, status, temperature_raw,
                  output ready);
endinterface

interface owm_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] conversion_wait_us;
  modport source (output valid, conversion_wait_us, input ready);
  modport sink   (input valid, conversion_wait_us, output ready);
endinterface

FILE: src/owm_seq.sv
// Bus sequencer: phase state, tick counter, command and read shift registers.
`timescale 1ns / 1ps
module owm_seq
  import owm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  item_t            item,
  input  logic [CFG_W-1:0] conv_wait,
  output res_t             res
);

  phase_t             phase_r, phase_nxt;
  cnt_t               cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]         bit_r, bit_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [15:0]        shift_r, shift_nxt;
  logic               pres_r, pres_nxt;
  logic               second_r, second_nxt;
  logic               status_r, status_nxt;
  logic signed [15:0] value_r, value_nxt;
  logic               done;
  logic [7:0]         cmd_byte;
  logic               wr_bit;
  len_t               conv_len;
  len_t               len;
  logic               phase_end;

  always_comb begin
    if (cmd_r == 2'd0) begin
      cmd_byte = CMD_SKIP;
    end else if (second_r) begin
      cmd_byte = CMD_READ;
    end else begin
      cmd_byte = CMD_CONV;
    end
    wr_bit = cmd_byte[bit_r[2:0]];
  end

  // Clamp the conversion wait to what the counter can reach
  always_comb begin
    if (len_t'(conv_wait) > len_t'(TIMER_MAX)) begin
      conv_len = len_t'(TIMER_MAX);
    end else begin
      conv_len = len_t'(conv_wait);
    end
  end

  always_comb begin
    case (phase_r)
      PH_RST_LOW:  len = LEN_RST_LOW;
      PH_RST_WAIT: len = LEN_RST_WAIT;
      PH_RST_REC:  len = LEN_RST_REC;
      PH_WR_LOW:   len = wr_bit ? LEN_WR1_LOW : LEN_WR0_LOW;
      PH_WR_HIGH:  len = wr_bit ? LEN_WR1_HIGH : LEN_WR0_HIGH;
      PH_CONV:     len = conv_len;
      PH_RD_LOW:   len = LEN_RD_LOW;
      PH_RD_WAIT:  len = LEN_RD_WAIT;
      PH_RD_REC:   len = LEN_RD_REC;
      default:     len = '0;
    endcase
  end

  assign cnt_inc   = (item.us_tick && (cnt_r != TIMER_MAX)) ? cnt_r + cnt_t'(1) : cnt_r;
  assign phase_end = len_t'(cnt_inc) >= len;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    bit_nxt    = bit_r;
    cmd_nxt    = cmd_r;
    shift_nxt  = shift_r;
    pres_nxt   = pres_r;
    second_nxt = second_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    done       = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.start_req) begin
        phase_nxt  = PH_RST_LOW;
        cnt_nxt    = '0;
        second_nxt = 1'b0;
        pres_nxt   = 1'b0;
        bit_nxt    = '0;
        cmd_nxt    = '0;
      end
    end else if (!phase_end) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = '0;
      case (phase_r)
        PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
        PH_RST_WAIT: begin
          pres_nxt  = ~item.line_level;
          phase_nxt = PH_RST_REC;
        end
        PH_RST_REC: begin
          if (!pres_r) begin
            status_nxt = 1'b1;
            value_nxt  = '0;
            done       = 1'b1;
            phase_nxt  = PH_IDLE;
          end else begin
            bit_nxt   = '0;
            cmd_nxt   = '0;
            phase_nxt = PH_WR_LOW;
          end
        end
        PH_WR_LOW:   phase_nxt = PH_WR_HIGH;
        PH_WR_HIGH: begin
          if (bit_r >= 4'd7) begin
            bit_nxt = '0;
            if (cmd_r >= 2'd1) begin
              cmd_nxt = '0;
              if (!second_r) begin
                phase_nxt = PH_CONV;
              end else begin
                shift_nxt = '0;
                phase_nxt = PH_RD_LOW;
              end
            end else begin
              cmd_nxt   = cmd_r + 2'd1;
              phase_nxt = PH_WR_LOW;
            end
          end else begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = PH_WR_LOW;
          end
        end
        PH_CONV: begin
          second_nxt = 1'b1;
          phase_nxt  = PH_RST_LOW;
        end
        PH_RD_LOW:   phase_nxt = PH_RD_WAIT;
        PH_RD_WAIT: begin
          shift_nxt[bit_r] = shift_r[bit_r] | item.line_level;
          phase_nxt        = PH_RD_REC;
        end
        PH_RD_REC: begin
          if (bit_r >= 4'd15) begin
            status_nxt = 1'b0;
            value_nxt  = shift_r;
            done       = 1'b1;
            bit_nxt    = '0;
            phase_nxt  = PH_IDLE;
          end else begin
            bit_nxt   = bit_r + 4'd1;
            phase_nxt = PH_RD_LOW;
          end
        end
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Result of this cycle, taken from the state after it
  always_comb begin
    res.drive_low       = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                          (phase_nxt == PH_RD_LOW);
    res.busy_res        = phase_nxt != PH_IDLE;
    res.done_res        = done;
    res.status          = status_nxt;
    res.temperature_raw = value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= '0;
      bit_r    <= '0;
      cmd_r    <= '0;
      shift_r  <= '0;
      pres_r   <= 1'b0;
      second_r <= 1'b0;
      status_r <= 1'b0;
      value_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      bit_r    <= bit_nxt;
      cmd_r    <= cmd_nxt;
      shift_r  <= shift_nxt;
      pres_r   <= pres_nxt;
      second_r <= second_nxt;
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  a_idle_stays : assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_IDLE) && !item.start_req |=> phase_r == PH_IDLE)
    else $error("sequencer left idle without a start request");

  a_good_done_from_read : assert property (@(posedge clk) disable iff (!rst_n)
    step && done && !status_nxt |-> phase_r == PH_RD_REC)
    else $error("good reading reported outside the last read slot");

  a_cmd_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r <= 2'd1)
    else $error("command index beyond the second command");

endmodule

FILE: src/onewire_temperature_read_master.sv
// Top level: single-wire bus master that reads one temperature sample.
//
//  channel | modport     | transaction payload
//  --------+-------------+-----------------------------------------------------
//  in_ch   | sink        | start_req, us_tick, line_level (one clock of bus time)
//  out_ch  | source      | drive_low, busy_res, done_res, status, temperature_raw
//  cfg_ch  | sink        | conversion_wait_us (20 bit), always ready
//
//  One input transaction yields one result transaction, one per clock when both
//  sides flow; each passes the input register, then the result register.
//  The tick add and phase compare of the sequencer set the critical path.
//  Reset (rst_n low, synchronous) empties both registers, idles the sequencer
//  and sets the conversion wait to 750000 us. A stalled result holds; the input
//  register takes one more transaction, then in_ch.ready drops until it moves.
`timescale 1ns / 1ps
module onewire_temperature_read_master
  import owm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  owm_in_if.sink    in_ch,
  owm_out_if.source out_ch,
  owm_cfg_if.sink   cfg_ch
);

  logic             in_vld_r;
  item_t            in_r;
  logic             out_vld_r;
  res_t             out_r;
  res_t             res;
  logic             advance;
  logic [CFG_W-1:0] conv_wait_r;

  // Move the held item into the result register when that register is free
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign cfg_ch.ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= CONV_WAIT_RESET;
    end else if (cfg_ch.valid) begin
      conv_wait_r <= cfg_ch.conversion_wait_us;
    end
  end

  // Input register: hold the accepted item until the sequencer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.start_req  <= in_ch.start_req;
      in_r.us_tick    <= in_ch.us_tick;
      in_r.line_level <= in_ch.line_level;
    end
  end

  owm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_r),
    .conv_wait (conv_wait_r),
    .res       (res)
  );

  // Result register: drop the valid once taken, unless a new result arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.drive_low       = out_r.drive_low;
  assign out_ch.busy_res        = out_r.busy_res;
  assign out_ch.done_res        = out_r.done_res;
  assign out_ch.status          = out_r.status;
  assign out_ch.temperature_raw = out_r.temperature_raw;

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled while the result register is empty");

  a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.done_res |-> !out_r.busy_res)
    else $error("done reported while still busy");

  a_drive_only_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.drive_low |-> out_r.busy_res)
    else $error("line driven low outside a sequence");

endmodule

FILE: verif/onewire_temperature_read_master_tb.sv
// Self-checking testbench for the single-wire temperature read master.
`timescale 1ns / 1ps
module onewire_temperature_read_master_tb;
  import owm_pkg::*;

  // Bus timing in microseconds.
  localparam int unsigned RESET_LOW_US   = 480;
  localparam int unsigned PRESENCE_US    = 70;
  localparam int unsigned RESET_REC_US   = 410;
  localparam int unsigned ONE_LOW_US     = 6;
  localparam int unsigned ONE_HIGH_US    = 64;
  localparam int unsigned ZERO_LOW_US    = 60;
  localparam int unsigned ZERO_HIGH_US   = 10;
  localparam int unsigned SLOT_LOW_US    = 6;
  localparam int unsigned SLOT_SAMPLE_US = 9;
  localparam int unsigned SLOT_REC_US    = 55;
  localparam int unsigned TICK_CEIL      = 32'((64'd1 << TIMER_BITS) - 64'd1);
  localparam logic [19:0] WAIT_AT_RESET  = 20'd750000;
  localparam logic [19:0] WAIT_LONGEST   = 20'hFFFFF;
  localparam int          REPORT_LIMIT   = 10;

  logic clk = 1'b0;
  logic rst_n;

  owm_in_if  in_ch();
  owm_out_if out_ch();
  owm_cfg_if cfg_ch();

  onewire_temperature_read_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted sequencer state, mirrored from the bus protocol.
  phase_t      seq_phase;
  int unsigned tick_count;
  logic [3:0]  bit_pos;
  logic [1:0]  cmd_pos;
  logic [15:0] shift_reg;
  logic        presence;
  logic        second_read;
  logic        last_status;
  logic [15:0] last_reading;
  logic [19:0] wait_setting;

  // One predicted line state per accepted cycle, oldest first.
  res_t awaited_results[$];

  int mismatches = 0;
  bit gaps_on    = 1'b1;

  // Gap length: mostly none, sometimes a few cycles, now and then a long one.
  function automatic int gap_length();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit coin(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Advance the predicted sequencer by one clock of bus time and return the
  // line state the block must show afterwards.
  function automatic res_t advance_sequencer(input item_t it);
    res_t        r;
    logic        done;
    logic [7:0]  wr_cmd;
    logic        wr_one;
    int unsigned span;
    done   = 1'b0;
    wr_cmd = (cmd_pos == 2'd0) ? CMD_SKIP : (second_read ? CMD_READ : CMD_CONV);
    wr_one = wr_cmd[bit_pos[2:0]];
    case (seq_phase)
      PH_RST_LOW:  span = RESET_LOW_US;
      PH_RST_WAIT: span = PRESENCE_US;
      PH_RST_REC:  span = RESET_REC_US;
      PH_WR_LOW:   span = wr_one ? ONE_LOW_US : ZERO_LOW_US;
      PH_WR_HIGH:  span = wr_one ? ONE_HIGH_US : ZERO_HIGH_US;
      // clamp the wait to what the tick counter can reach
      PH_CONV:     span = (wait_setting > TICK_CEIL) ? TICK_CEIL : wait_setting;
      PH_RD_LOW:   span = SLOT_LOW_US;
      PH_RD_WAIT:  span = SLOT_SAMPLE_US;
      PH_RD_REC:   span = SLOT_REC_US;
      default:     span = 0;
    endcase

    if (seq_phase == PH_IDLE) begin
      // the start cycle counts no tick
      if (it.start_req) begin
        seq_phase   = PH_RST_LOW;
        tick_count  = 0;
        second_read = 1'b0;
        presence    = 1'b0;
        bit_pos     = '0;
        cmd_pos     = '0;
      end
    end else begin
      if (it.us_tick && tick_count < TICK_CEIL) tick_count++;
      if (tick_count >= span) begin
        tick_count = 0;
        case (seq_phase)
          PH_RST_LOW:  seq_phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence  = ~it.line_level;
            seq_phase = PH_RST_REC;
          end
          PH_RST_REC: begin
            if (!presence) begin
              last_status  = 1'b1;
              last_reading = '0;
              done         = 1'b1;
              seq_phase    = PH_IDLE;
            end else begin
              bit_pos   = '0;
              cmd_pos   = '0;
              seq_phase = PH_WR_LOW;
            end
          end
          PH_WR_LOW:   seq_phase = PH_WR_HIGH;
          PH_WR_HIGH: begin
            if (bit_pos >= 4'd7) begin
              bit_pos = '0;
              cmd_pos = cmd_pos + 2'd1;
              if (cmd_pos >= 2'd2) begin
                cmd_pos = '0;
                if (!second_read) begin
                  seq_phase = PH_CONV;
                end else begin
                  shift_reg = '0;
                  seq_phase = PH_RD_LOW;
                end
              end else begin
                seq_phase = PH_WR_LOW;
              end
            end else begin
              bit_pos   = bit_pos + 4'd1;
              seq_phase = PH_WR_LOW;
            end
          end
          PH_CONV: begin
            second_read = 1'b1;
            seq_phase   = PH_RST_LOW;
          end
          PH_RD_LOW:   seq_phase = PH_RD_WAIT;
          PH_RD_WAIT: begin
            shift_reg = shift_reg | (16'(it.line_level) << bit_pos);
            seq_phase = PH_RD_REC;
          end
          PH_RD_REC: begin
            if (bit_pos >= 4'd15) begin
              last_status  = 1'b0;
              last_reading = shift_reg;
              done         = 1'b1;
              bit_pos      = '0;
              seq_phase    = PH_IDLE;
            end else begin
              bit_pos   = bit_pos + 4'd1;
              seq_phase = PH_RD_LOW;
            end
          end
          default:     seq_phase = PH_IDLE;
        endcase
      end
    end

    r.drive_low       = (seq_phase == PH_RST_LOW) || (seq_phase == PH_WR_LOW) ||
                        (seq_phase == PH_RD_LOW);
    r.busy_res        = (seq_phase != PH_IDLE);
    r.done_res        = done;
    r.status          = last_status;
    r.temperature_raw = last_reading;
    return r;
  endfunction

  // Send one clock of bus time; predict its line state once it is accepted.
  // Valid stays high afterwards so back-to-back transactions need no toggle.
  task automatic send_cycle(input bit start, input bit tick, input bit level);
    item_t it;
    int    gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_req  <= start;
    in_ch.us_tick    <= tick;
    in_ch.line_level <= level;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    it = {start, tick, level};
    awaited_results.push_back(advance_sequencer(it));
  endtask

  // Drop valid and hold until every predicted result has come out.
  task automatic drain();
    if (awaited_results.size() != 0) begin
      in_ch.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
    end
  endtask

  // Write the conversion wait; only ever done with the block idle and empty.
  task automatic write_wait_setting(input logic [19:0] value);
    drain();
    cfg_ch.valid              <= 1'b1;
    cfg_ch.conversion_wait_us <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    wait_setting = value;
  endtask

  // Play the sensor through one whole measurement: pull the line low for a
  // presence pulse when asked and return the reading bit by bit in the read
  // slots. Noise flips the line at random, which can break a presence pulse
  // or corrupt a bit; the prediction follows whatever is really sent.
  task automatic run_measurement(input bit first_present, input bit second_present,
                                 input logic [15:0] reading, input int tick_pct,
                                 input int start_pct, input int noise_pct,
                                 input int pause_at);
    int n;
    bit level;
    n = 0;
    repeat ($urandom_range(1, 4)) send_cycle(1'b0, coin(tick_pct), coin(50));
    send_cycle(1'b1, coin(tick_pct), coin(50));
    while (seq_phase != PH_IDLE) begin
      case (seq_phase)
        PH_RST_WAIT: level = second_read ? !second_present : !first_present;
        PH_RD_WAIT:  level = reading[bit_pos];
        default:     level = coin(50);
      endcase
      if (coin(noise_pct)) level = ~level;
      n++;
      if (n == pause_at) drain();
      send_cycle(coin(start_pct), coin(tick_pct), level);
    end
  endtask

  // Idle cycles straight after reset: ticks and line must be ignored and the
  // held status and reading must read zero.
  task automatic test_idle_after_reset();
    send_cycle(1'b0, 1'b0, 1'b0);
    send_cycle(1'b0, 1'b1, 1'b1);
    send_cycle(1'b0, 1'b1, 1'b0);
    send_cycle(1'b0, 1'b0, 1'b1);
    drain();
  endtask

  // No presence pulse after the first reset, at the reset-time wait and at
  // the longest wait: the sequence must end at once with the no-device status.
  task automatic test_absent_device();
    run_measurement(1'b0, 1'b0, 16'h1234, 100, 0, 0, 0);
    drain();
    write_wait_setting(WAIT_LONGEST);
    run_measurement(1'b0, 1'b1, 16'h5678, 100, 50, 0, 0);
    drain();
  endtask

  // Zero conversion wait ends without a tick; read the most negative value.
  task automatic test_zero_wait();
    write_wait_setting(20'd0);
    run_measurement(1'b1, 1'b1, 16'h8000, 100, 5, 0, 0);
    drain();
  endtask

  // Extremes of the reading, each after a one-microsecond wait.
  task automatic test_reading_extremes();
    write_wait_setting(20'd1);
    run_measurement(1'b1, 1'b1, 16'h7FFF, 100, 0, 0, 0);
    run_measurement(1'b1, 1'b1, 16'hFFFF, 100, 0, 0, 0);
    run_measurement(1'b1, 1'b1, 16'h0000, 100, 0, 0, 0);
    drain();
  endtask

  // Sensor answers the first reset but not the one after the conversion:
  // the reading must drop to zero with the no-device status.
  task automatic test_absent_after_convert();
    write_wait_setting(20'd25);
    run_measurement(1'b1, 1'b0, 16'($urandom), 100, 5, 0, 0);
    drain();
  endtask

  // Start held high for the whole sequence must change nothing.
  task automatic test_start_while_busy();
    write_wait_setting(20'd2);
    run_measurement(1'b1, 1'b1, 16'($urandom), 100, 100, 0, 0);
    drain();
  endtask

  // Sparse microsecond strobes stretch every phase.
  task automatic test_sparse_ticks();
    write_wait_setting(20'd3);
    run_measurement(1'b1, 1'b1, 16'($urandom), 35, 10, 0, 0);
    drain();
  endtask

  // Stop sending part-way through the second reset until the pipe is empty,
  // with no idling on either side before or after.
  task automatic test_pause_mid_sequence();
    write_wait_setting(20'd10);
    gaps_on = 1'b0;
    run_measurement(1'b1, 1'b1, 16'($urandom), 100, 5, 0, 3000);
    drain();
    gaps_on = 1'b1;
  endtask

  // Random measurements: mostly well-formed with random readings, waits and
  // strobe rates, some with a missing sensor, line noise or a mid-way pause.
  task automatic test_random_measurements();
    logic [19:0] wait_us;
    int          pick;
    for (int k = 0; k < 8; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      wait_us = 20'd0;
      else if (pick == 1) wait_us = 20'd1;
      else                wait_us = 20'($urandom_range(2, 400));
      write_wait_setting(wait_us);
      gaps_on = coin(75);
      run_measurement(coin(85), coin(85), 16'($urandom), $urandom_range(60, 100),
                      $urandom_range(0, 30), $urandom_range(0, 3),
                      coin(20) ? $urandom_range(1, 5000) : 0);
    end
    drain();
    gaps_on = 1'b1;
  endtask

  // Result side: stall at random, compare each accepted transaction with the
  // oldest prediction.
  initial begin : result_check
    res_t got;
    res_t want;
    int   stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.drive_low, out_ch.busy_res, out_ch.done_res, out_ch.status,
               out_ch.temperature_raw};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with none expected: ", $time,
                     "drive_low=%0b busy=%0b done=%0b ", got.drive_low, got.busy_res,
                     got.done_res,
                     "status=%0b temperature_raw=%0d", got.status, got.temperature_raw);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: mismatch: ", $time,
                       "expected drive_low=%0b busy=%0b done=%0b ", want.drive_low,
                       want.busy_res, want.done_res,
                       "status=%0b temperature_raw=%0d, ", want.status,
                       want.temperature_raw,
                       "got drive_low=%0b busy=%0b done=%0b ", got.drive_low,
                       got.busy_res, got.done_res,
                       "status=%0b temperature_raw=%0d", got.status,
                       got.temperature_raw);
          end
        end
      end
      if (rst_n !== 1'b1) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (stall == 0) stall = gap_length();
        if (stall > 0) begin
          stall--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Main sequence: reset once, then run each test in turn.
  initial begin
    rst_n                     <= 1'b0;
    in_ch.valid               <= 1'b0;
    in_ch.start_req           <= 1'b0;
    in_ch.us_tick             <= 1'b0;
    in_ch.line_level          <= 1'b1;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.conversion_wait_us <= '0;

    // initialise the prediction to the block's state after reset
    seq_phase    = PH_IDLE;
    tick_count   = 0;
    bit_pos      = '0;
    cmd_pos      = '0;
    shift_reg    = '0;
    presence     = 1'b0;
    second_read  = 1'b0;
    last_status  = 1'b0;
    last_reading = '0;
    wait_setting = WAIT_AT_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_after_reset();
    test_absent_device();
    test_zero_wait();
    test_reading_extremes();
    test_absent_after_convert();
    test_start_while_busy();
    test_sparse_ticks();
    test_pause_mid_sequence();
    test_random_measurements();

    // let the two-stage pipe settle before the verdict
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
